// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, off while rst_n is low
`define SVV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every clock edge out of reset
`define SVV_ASSERT_NOW(name, cond, msg) \
  `SVV_ASSERT(name, (cond), msg)

`endif

// File: src/svv_pkg.sv
// ----------------------------------------------------------------------------
// svv_pkg
// Types, character codes, result codes and helpers of the version checker.
// ----------------------------------------------------------------------------
package svv_pkg;

  // Position counter saturates at the last offset of the longest string
  localparam int MAX_LEN   = 256;
  localparam int POS_CAP_I = ((MAX_LEN - 1) < 255) ? (MAX_LEN - 1) : 255;
  localparam logic [7:0] POS_CAP = 8'(POS_CAP_I);

  // Queue between classifier and parser
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_MISSING  = 3'd2;
  localparam logic [2:0] ST_BAD_PRE  = 3'd3;
  localparam logic [2:0] ST_BAD_META = 3'd4;
  localparam logic [2:0] ST_GARBAGE  = 3'd5;

  // One classified byte, as queued
  typedef struct packed {
    logic [7:0] ch;
    logic       is_nul;
    logic       is_digit;
    logic       is_ident;
    logic       is_dot;
    logic       is_minus;
    logic       is_plus;
  } chr_class_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] major_num;
    logic [31:0] minor_num;
    logic [31:0] patch_num;
    logic        has_prerelease;
    logic [7:0]  prerelease_start;
    logic [7:0]  prerelease_length;
    logic        has_metadata;
    logic [7:0]  metadata_start;
    logic [7:0]  metadata_length;
  } result_t;

  // acc*10 + digit as two shifts and adds, wrapping at 32 bits
  function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [3:0] dig);
    return (acc << 3) + (acc << 1) + {28'd0, dig};
  endfunction

  function automatic logic [7:0] sat_next(input logic [7:0] p);
    return (p < POS_CAP) ? p + 8'd1 : POS_CAP;
  endfunction

endpackage

// File: src/semver_string_validator.sv
// ----------------------------------------------------------------------------
// semver_string_validator: one byte per cycle while queue has room; result registered on out.
// Front, 4-entry queue, parser step independently; parser takes one byte a cycle unless out stalls.
// Reset (rst_n low, synchronous) empties the queue and output, starts a new string.
// ----------------------------------------------------------------------------
module semver_string_validator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] ch
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // major_num, minor_num, patch_num, has_prerelease,
                                   // prerelease_start, prerelease_length, has_metadata,
                                   // metadata_start, metadata_length, zero pad
  output logic [2:0]   out_tuser   // [2:0] status
);
  import svv_pkg::*;

  chr_class_t push_entry;
  chr_class_t pop_entry;
  logic       q_push;
  logic       q_ready;
  logic       q_pop;
  logic       q_valid;
  result_t    res;

  svv_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  svv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  svv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Result beat packing, first field lowest
  assign out_tuser = res.status;
  assign out_tdata = {22'd0, res.metadata_length, res.metadata_start, res.has_metadata,
                      res.prerelease_length, res.prerelease_start, res.has_prerelease,
                      res.patch_num, res.minor_num, res.major_num};

endmodule

// File: src/svv_front.sv
// ----------------------------------------------------------------------------
// svv_front
// Input side: takes byte beats and tags each with its character class.
// ----------------------------------------------------------------------------
module svv_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                q_ready,
  output logic                q_push,
  output svv_pkg::chr_class_t q_entry
);
  import svv_pkg::*;

  logic dig;
  logic alpha;

  // Handshake follows queue space
  assign in_tready = q_ready;
  assign q_push    = in_tvalid & q_ready;

  // Character classes
  always_comb begin
    dig   = (in_tdata inside {[CH_D0:CH_D9]});
    alpha = (in_tdata inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]});
    q_entry.ch       = in_tdata;
    q_entry.is_nul   = (in_tdata == CH_NUL);
    q_entry.is_digit = dig;
    q_entry.is_ident = dig | alpha | (in_tdata == CH_MINUS);
    q_entry.is_dot   = (in_tdata == CH_DOT);
    q_entry.is_minus = (in_tdata == CH_MINUS);
    q_entry.is_plus  = (in_tdata == CH_PLUS);
  end

endmodule

// File: src/svv_queue.sv
// ----------------------------------------------------------------------------
// svv_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svv_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  svv_pkg::chr_class_t push_entry,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output svv_pkg::chr_class_t pop_entry
);
  import svv_pkg::*;

  chr_class_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `SVV_ASSERT_NOW(a_q_cnt_range, cnt_r <= Q_CW'(Q_DEPTH), "queue count over depth")
  `SVV_ASSERT_NOW(a_q_ptr_gap, (wr_ptr_r - rd_ptr_r) == Q_AW'(cnt_r), "queue pointers disagree with count")

endmodule

// File: src/svv_back.sv
// ----------------------------------------------------------------------------
// svv_back
// Parser: walks one classified byte a cycle, while the output slot is free or draining,
// through the version grammar and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  svv_pkg::chr_class_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output svv_pkg::result_t    out_res
);
  import svv_pkg::*;

  // Parser phases
  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_MAJ       = 4'd1;
  localparam logic [3:0] PH_MIN_FIRST = 4'd2;
  localparam logic [3:0] PH_MIN       = 4'd3;
  localparam logic [3:0] PH_PAT_FIRST = 4'd4;
  localparam logic [3:0] PH_PAT       = 4'd5;
  localparam logic [3:0] PH_ID_START  = 4'd6;
  localparam logic [3:0] PH_ID_DIGITS = 4'd7;
  localparam logic [3:0] PH_ID_ALNUM  = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] major_r, major_nxt;
  logic [31:0] minor_r, minor_nxt;
  logic [31:0] patch_r, patch_nxt;
  logic        lz_r, lz_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  pre_start_r, pre_start_nxt;
  logic [7:0]  pre_len_r, pre_len_nxt;
  logic [7:0]  meta_start_r, meta_start_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic        skip_r, skip_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  logic        step;
  logic        emit;
  logic [3:0]  dig;

  // Step when a byte waits and the output slot is free or draining
  assign step      = q_valid & (~out_valid_r | out_ready);
  assign q_pop     = step;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign dig       = q_entry.ch[3:0];

  // Grammar step
  always_comb begin
    logic       t_patch, t_sec, t_pre, t_end;
    logic       err, ok, new_str;
    logic [2:0] err_code;
    logic [2:0] sec_err;
    logic [31:0] patch_v;
    logic [7:0]  pre_len_v;

    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    major_nxt      = major_r;
    minor_nxt      = minor_r;
    patch_nxt      = patch_r;
    lz_nxt         = lz_r;
    pos_nxt        = pos_r;
    pre_start_nxt  = pre_start_r;
    pre_len_nxt    = pre_len_r;
    meta_start_nxt = meta_start_r;
    flags_nxt      = flags_r;
    skip_nxt       = skip_r;
    t_patch        = 1'b0;
    t_sec          = 1'b0;
    t_pre          = 1'b0;
    t_end          = 1'b0;
    err            = 1'b0;
    ok             = 1'b0;
    new_str        = 1'b0;
    err_code       = ST_GARBAGE;
    sec_err        = flags_r[1] ? ST_BAD_META : ST_BAD_PRE;
    patch_v        = patch_r;
    pre_len_v      = pre_len_r;
    res_nxt        = '0;
    emit           = 1'b0;

    if (step) begin
      if (skip_r) begin
        new_str = q_entry.is_nul;
      end else begin
        pos_nxt = sat_next(pos_r);
        case (phase_r)
          PH_START, PH_MIN_FIRST, PH_PAT_FIRST: begin
            if (phase_r == PH_START && q_entry.is_nul) begin
              err      = 1'b1;
              err_code = ST_EMPTY;
            end else if (!q_entry.is_digit) begin
              err      = 1'b1;
              err_code = ST_MISSING;
            end else begin
              lz_nxt    = (q_entry.ch == CH_D0);
              acc_nxt   = {28'd0, dig};
              phase_nxt = (phase_r == PH_START) ? PH_MAJ : phase_r + 4'd1;
            end
          end
          PH_MAJ, PH_MIN, PH_PAT: begin
            if (q_entry.is_digit) begin
              acc_nxt = mul10_add(acc_r, dig);
            end else if (lz_r && acc_r != '0) begin
              err      = 1'b1;
              err_code = ST_MISSING;
            end else if (phase_r == PH_PAT) begin
              patch_v   = acc_r;
              patch_nxt = acc_r;
              t_patch   = 1'b1;
            end else if (!q_entry.is_dot) begin
              err      = 1'b1;
              err_code = ST_MISSING;
            end else if (phase_r == PH_MAJ) begin
              major_nxt = acc_r;
              phase_nxt = PH_MIN_FIRST;
            end else begin
              minor_nxt = acc_r;
              phase_nxt = PH_PAT_FIRST;
            end
          end
          PH_ID_START: begin
            if (q_entry.is_digit) begin
              lz_nxt    = (q_entry.ch == CH_D0);
              acc_nxt   = {28'd0, dig};
              phase_nxt = PH_ID_DIGITS;
            end else if (q_entry.is_ident) begin
              phase_nxt = PH_ID_ALNUM;
            end else if (!q_entry.is_dot) begin
              t_sec = 1'b1;
            end
          end
          PH_ID_DIGITS: begin
            if (q_entry.is_digit) begin
              acc_nxt = mul10_add(acc_r, dig);
            end else if (lz_r && (acc_r != '0 || q_entry.is_minus)) begin
              err      = 1'b1;
              err_code = sec_err;
            end else if (q_entry.is_minus) begin
              phase_nxt = PH_ID_ALNUM;
            end else if (q_entry.is_dot) begin
              phase_nxt = PH_ID_START;
            end else begin
              t_sec = 1'b1;
            end
          end
          PH_ID_ALNUM: begin
            if (q_entry.is_dot) begin
              phase_nxt = PH_ID_START;
            end else if (!q_entry.is_ident) begin
              t_sec = 1'b1;
            end
          end
          default: begin
            new_str = 1'b1;
          end
        endcase

        // End of patch number: pre-release may open
        if (t_patch) begin
          if (q_entry.is_minus) begin
            flags_nxt[0]  = 1'b1;
            pre_start_nxt = sat_next(pos_r);
            phase_nxt     = PH_ID_START;
          end else begin
            t_pre = 1'b1;
          end
        end

        // End of an identifier run: close the open section
        if (t_sec) begin
          if (flags_r[1]) begin
            t_end = 1'b1;
          end else begin
            pre_len_v   = pos_r - pre_start_r;
            pre_len_nxt = pre_len_v;
            t_pre       = 1'b1;
          end
        end

        // Build metadata may open
        if (t_pre) begin
          if (q_entry.is_plus) begin
            flags_nxt[1]   = 1'b1;
            meta_start_nxt = sat_next(pos_r);
            phase_nxt      = PH_ID_START;
          end else begin
            t_end = 1'b1;
          end
        end

        // Only the terminator may follow
        if (t_end) begin
          if (q_entry.is_nul) begin
            ok = 1'b1;
          end else begin
            err      = 1'b1;
            err_code = ST_GARBAGE;
          end
        end

        // Result beat
        if (err) begin
          emit           = 1'b1;
          res_nxt.status = err_code;
          if (q_entry.is_nul) begin
            new_str = 1'b1;
          end else begin
            skip_nxt = 1'b1;
          end
        end else if (ok) begin
          emit                      = 1'b1;
          new_str                   = 1'b1;
          res_nxt.status            = ST_OK;
          res_nxt.major_num         = major_r;
          res_nxt.minor_num         = minor_r;
          res_nxt.patch_num         = patch_v;
          res_nxt.has_prerelease    = flags_r[0];
          res_nxt.prerelease_start  = flags_r[0] ? pre_start_r : 8'd0;
          res_nxt.prerelease_length = flags_r[0] ? pre_len_v : 8'd0;
          res_nxt.has_metadata      = flags_r[1];
          res_nxt.metadata_start    = flags_r[1] ? meta_start_r : 8'd0;
          res_nxt.metadata_length   = flags_r[1] ? pos_r - meta_start_r : 8'd0;
        end
      end

      // Fresh string state
      if (new_str) begin
        phase_nxt      = PH_START;
        acc_nxt        = '0;
        major_nxt      = '0;
        minor_nxt      = '0;
        patch_nxt      = '0;
        lz_nxt         = 1'b0;
        pos_nxt        = '0;
        pre_start_nxt  = '0;
        pre_len_nxt    = '0;
        meta_start_nxt = '0;
        flags_nxt      = '0;
        skip_nxt       = 1'b0;
      end
    end
  end

  // Output slot
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      acc_r        <= '0;
      major_r      <= '0;
      minor_r      <= '0;
      patch_r      <= '0;
      lz_r         <= 1'b0;
      pos_r        <= '0;
      pre_start_r  <= '0;
      pre_len_r    <= '0;
      meta_start_r <= '0;
      flags_r      <= '0;
      skip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      major_r      <= major_nxt;
      minor_r      <= minor_nxt;
      patch_r      <= patch_nxt;
      lz_r         <= lz_nxt;
      pos_r        <= pos_nxt;
      pre_start_r  <= pre_start_nxt;
      pre_len_r    <= pre_len_nxt;
      meta_start_r <= meta_start_nxt;
      flags_r      <= flags_nxt;
      skip_r       <= skip_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload, loaded only on a new beat
  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  `SVV_ASSERT(a_skip_silent, (step && skip_r) |-> !emit, "result while skipping")
  `SVV_ASSERT(a_nul_restarts, (step && q_entry.is_nul) |=> (phase_r == PH_START && !skip_r && pos_r == 8'd0), "terminator did not restart")
  `SVV_ASSERT_NOW(a_err_zero, !(out_valid_r && res_r.status != ST_OK) || (res_r.major_num == '0 && res_r.patch_num == '0 && !res_r.has_prerelease && !res_r.has_metadata && res_r.metadata_length == '0), "error beat with nonzero fields")

endmodule
